// ----- src/nhw_pkg.sv -----
// nhw_pkg: shared types, sizes and codes of the node health watchdog
// used by nhw_ctrl, nhw_dpath and node_health_watchdog; no dependencies
package nhw_pkg;

  localparam int SLOTS = 12;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int REPORT_LEN = 16 + 2 * SLOTS;
  localparam int CNT_W = 6;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_NODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_CODE = 3'd4;

  localparam logic [31:0] DEAD_TIMEOUT_RST = 32'd1000;
  localparam logic [31:0] REPORT_PERIOD_RST = 32'd1000;

  localparam logic [CNT_W-1:0] BYTE_CODE = 6'd0;
  localparam logic [CNT_W-1:0] BYTE_N_PRESENT = 6'd1;
  localparam logic [CNT_W-1:0] BYTE_N_ALIVE = 6'd2;
  localparam logic [CNT_W-1:0] BYTE_VER_LO = 6'd3;
  localparam logic [CNT_W-1:0] BYTE_VER_HI = 6'd4;
  localparam logic [CNT_W-1:0] BYTE_FLAGS = 6'd5;
  localparam logic [CNT_W-1:0] BYTE_PRESENT_LO = 6'd6;
  localparam logic [CNT_W-1:0] BYTE_PRESENT_HI = 6'd7;
  localparam logic [CNT_W-1:0] BYTE_ALIVE_LO = 6'd8;
  localparam logic [CNT_W-1:0] BYTE_ALIVE_HI = 6'd9;
  localparam logic [CNT_W-1:0] BYTE_MISM_LO = 6'd10;
  localparam logic [CNT_W-1:0] BYTE_MISM_HI = 6'd11;
  localparam logic [CNT_W-1:0] BYTE_DUP_LO = 6'd12;
  localparam logic [CNT_W-1:0] BYTE_DUP_HI = 6'd13;
  localparam logic [CNT_W-1:0] BYTE_DEAD_LO = 6'd14;
  localparam logic [CNT_W-1:0] BYTE_DEAD_HI = 6'd15;
  localparam logic [CNT_W-1:0] BYTE_LAST = CNT_W'(REPORT_LEN - 1);

  localparam logic [7:0] FLAG_MISMATCH = 8'h01;
  localparam logic [7:0] FLAG_DUPLICATE = 8'h02;
  localparam logic [7:0] FLAG_DEAD = 8'h04;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_ALIVE = 2'd1;
  localparam logic [1:0] ST_DEAD = 2'd2;
  localparam logic [1:0] ST_DUP = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [15:0] node_id;
    logic [7:0]  node_version;
    logic [31:0] now_ms;
    logic [15:0] duplicate_mask;
  } item_t;

  typedef struct packed {
    logic [5:0] byte_index;
    logic [7:0] byte_value;
    logic       last_byte;
  } result_t;

  typedef struct packed {
    logic load;
    logic process;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic due;
    logic last;
  } stat_t;

  function automatic logic [4:0] count16(input logic [15:0] v);
    logic [4:0] n;
    n = '0;
    for (int k = 0; k < 16; k++) begin
      n = n + 5'(v[k]);
    end
    return n;
  endfunction

endpackage

// ----- src/nhw_ctrl.sv -----
// nhw_ctrl: sequencer of the watchdog, one item at a time
// depends on nhw_pkg; drives nhw_dpath through cmd_t, reads stat_t
module nhw_ctrl import nhw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE  = 3'b001,
    CHECK = 3'b010,
    EMIT  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: begin
        if (start) state_next = CHECK;
      end
      CHECK: begin
        if (stat.is_tick && stat.due) state_next = EMIT;
        else state_next = IDLE;
      end
      EMIT: begin
        if (stat.last) state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  assign busy = (state != IDLE);
  assign cmd.load = start && (state == IDLE);
  assign cmd.process = (state == CHECK);
  assign cmd.emit = (state == EMIT);

endmodule

// ----- src/nhw_dpath.sv -----
// nhw_dpath: slot table, configuration registers, mask build and byte output
// depends on nhw_pkg; controlled by nhw_ctrl through cmd_t
module nhw_dpath import nhw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  item_t                item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic                 strobe,
  output result_t              result
);

  logic [31:0] dead_timeout;
  logic [31:0] report_period;
  logic [15:0] expected_version;
  logic [15:0] first_node_id;
  logic [7:0]  report_code;

  item_t       item_r;
  logic [31:0] last_seen [SLOTS];
  logic [7:0]  slot_version [SLOTS];
  logic [SLOTS-1:0] slot_seen;
  logic [31:0] last_report;

  logic [15:0] present, alive, mism, dead;
  logic [15:0] alive_now, mism_now;
  logic [CNT_W-1:0] cnt;

  logic [15:0] slot_off;
  logic        slot_hit;
  logic        due;
  logic [4:0]  slot_full;
  logic [SLOT_W-1:0] slot;
  logic [7:0]  byte_val;
  logic [1:0]  status;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_timeout <= DEAD_TIMEOUT_RST;
      report_period <= REPORT_PERIOD_RST;
      expected_version <= '0;
      first_node_id <= '0;
      report_code <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEAD_TIMEOUT:  dead_timeout <= cfg_data;
        REG_REPORT_PERIOD: report_period <= cfg_data;
        REG_EXPECTED_VER:  expected_version <= cfg_data[15:0];
        REG_FIRST_NODE:    first_node_id <= cfg_data[15:0];
        REG_REPORT_CODE:   report_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= item;
  end

  // frame lookup and tick check
  assign slot_off = item_r.node_id - first_node_id;
  assign slot_hit = (item_r.node_id >= first_node_id) && (slot_off < 16'(SLOTS));
  assign due = (item_r.now_ms - last_report) >= report_period;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      alive_now[i] = 1'b0;
      mism_now[i] = 1'b0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      alive_now[i] = slot_seen[i] && ((item_r.now_ms - last_seen[i]) < dead_timeout);
      mism_now[i] = slot_seen[i] && (slot_version[i] != expected_version[7:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_seen <= '0;
      last_report <= '0;
      for (int i = 0; i < SLOTS; i++) slot_version[i] <= '0;
    end else if (cmd.process) begin
      if (!item_r.mode) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_hit && (slot_off == 16'(i))) begin
            slot_seen[i] <= 1'b1;
            slot_version[i] <= item_r.node_version;
          end
        end
      end else if (due) begin
        last_report <= item_r.now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.process && !item_r.mode) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_hit && (slot_off == 16'(i))) last_seen[i] <= item_r.now_ms;
      end
    end
  end

  // report snapshot
  always_ff @(posedge clk) begin
    if (cmd.process) begin
      present <= 16'(slot_seen);
      alive <= alive_now;
      mism <= mism_now;
      dead <= 16'(slot_seen) & ~alive_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.process) begin
      cnt <= '0;
    end else if (cmd.emit) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign slot_full = 5'(cnt[CNT_W-1:1] - 5'd8);
  assign slot = slot_full[SLOT_W-1:0];

  always_comb begin
    if (item_r.duplicate_mask[slot_full[3:0]]) status = ST_DUP;
    else if (dead[slot_full[3:0]]) status = ST_DEAD;
    else if (alive[slot_full[3:0]]) status = ST_ALIVE;
    else status = ST_NONE;
  end

  always_comb begin
    byte_val = '0;
    unique case (cnt)
      BYTE_CODE:       byte_val = report_code;
      BYTE_N_PRESENT:  byte_val = 8'(count16(present));
      BYTE_N_ALIVE:    byte_val = 8'(count16(alive));
      BYTE_VER_LO:     byte_val = expected_version[7:0];
      BYTE_VER_HI:     byte_val = expected_version[15:8];
      BYTE_FLAGS: begin
        byte_val = ((mism != '0) ? FLAG_MISMATCH : 8'h00)
                 | ((item_r.duplicate_mask != '0) ? FLAG_DUPLICATE : 8'h00)
                 | ((dead != '0) ? FLAG_DEAD : 8'h00);
      end
      BYTE_PRESENT_LO: byte_val = present[7:0];
      BYTE_PRESENT_HI: byte_val = present[15:8];
      BYTE_ALIVE_LO:   byte_val = alive[7:0];
      BYTE_ALIVE_HI:   byte_val = alive[15:8];
      BYTE_MISM_LO:    byte_val = mism[7:0];
      BYTE_MISM_HI:    byte_val = mism[15:8];
      BYTE_DUP_LO:     byte_val = item_r.duplicate_mask[7:0];
      BYTE_DUP_HI:     byte_val = item_r.duplicate_mask[15:8];
      BYTE_DEAD_LO:    byte_val = dead[7:0];
      BYTE_DEAD_HI:    byte_val = dead[15:8];
      default: begin
        if (slot_full < 5'(SLOTS)) begin
          if (cnt[0]) byte_val = 8'(status);
          else byte_val = slot_version[slot];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.byte_index <= cnt;
      result.byte_value <= byte_val;
      result.last_byte <= (cnt == BYTE_LAST);
    end
  end

  assign stat.is_tick = item_r.mode;
  assign stat.due = due;
  assign stat.last = (cnt == BYTE_LAST);

endmodule

// ----- src/node_health_watchdog.sv -----
// node_health_watchdog: top level of the node health monitor
// depends on nhw_pkg, nhw_ctrl and nhw_dpath
//
// usage
//   input: an item is taken when start is high and busy is low.
//     mode 0 records a frame from node_id (last-seen time and version);
//     mode 1 is a report tick carrying now_ms and duplicate_mask.
//   output: each report byte shows on result for one cycle with strobe
//     high; the receiver cannot hold bytes off. byte_index counts 0 up,
//     last_byte marks the final byte.
//   config: cfg_we, cfg_index, cfg_data write one register per cycle; the user
//     writes only with busy low (unenforced); indexes past the list are ignored.
//   timing: a frame or a tick that is not due keeps busy high only in the
//     CHECK state, then returns to IDLE; no item is taken while busy. a due tick builds
//     the slot masks in CHECK, then the byte sequencer sends
//     16 + 2 * SLOTS bytes, one per cycle; strobe for the first byte is
//     registered from the EMIT state, and busy drops with the last byte sent.
//   reset: rst clears slot seen flags, versions, last report time and
//     the registers to their defaults; no item is in flight afterwards.
module node_health_watchdog import nhw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 strobe,
  output result_t              result
);

  cmd_t  cmd;
  stat_t stat;

  nhw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  nhw_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .strobe    (strobe),
    .result    (result)
  );

endmodule

// ----- dv/node_health_watchdog_test.sv -----
`timescale 1ns / 100ps
// node_health_watchdog_test: self-checking bench for node_health_watchdog
// predicts every report byte from frames, ticks and register writes
// depends on nhw_pkg and the node_health_watchdog rtl
module node_health_watchdog_test;
  import nhw_pkg::*;

  localparam int HALF_PERIOD_NS = 4;
  localparam int RESET_CYCLES = 5;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 380;
  localparam int PHASES = 6;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_PRINTED = 40;
  localparam int SLOT_BASE = 16;
  localparam logic MODE_FRAME = 1'b0;
  localparam logic MODE_TICK = 1'b1;
  localparam int LAST_REG_INDEX = (1 << CFG_IDX_W) - 1;

  class health_report_model;
    logic [31:0] dead_timeout;
    logic [31:0] report_period;
    logic [15:0] own_version;
    logic [15:0] base_id;
    logic [7:0] code;
    logic [31:0] seen_at[SLOTS];
    logic [7:0] version_of[SLOTS];
    bit seen[SLOTS];
    logic [31:0] reported_at;
    result_t due_bytes[$];
    int mismatches;

    function new();
      dead_timeout = DEAD_TIMEOUT_RST;
      report_period = REPORT_PERIOD_RST;
      own_version = '0;
      base_id = '0;
      code = '0;
      reported_at = '0;
      foreach (seen[i]) begin
        seen[i] = 1'b0;
        seen_at[i] = '0;
        version_of[i] = '0;
      end
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
      case (index)
        REG_DEAD_TIMEOUT: dead_timeout = data;
        REG_REPORT_PERIOD: report_period = data;
        REG_EXPECTED_VER: own_version = data[15:0];
        REG_FIRST_NODE: base_id = data[15:0];
        REG_REPORT_CODE: code = data[7:0];
        default: ;
      endcase
    endfunction

    function void take_item(item_t it);
      logic [15:0] slot_off;
      logic [31:0] elapsed;
      logic [31:0] age;
      logic [15:0] present;
      logic [15:0] alive;
      logic [15:0] mism;
      logic [15:0] dead;
      logic [1:0] status;
      logic [7:0] payload[REPORT_LEN];
      result_t r;
      if (it.mode == MODE_FRAME) begin
        slot_off = it.node_id - base_id;
        if (it.node_id >= base_id && slot_off < SLOTS) begin
          seen_at[slot_off] = it.now_ms;
          version_of[slot_off] = it.node_version;
          seen[slot_off] = 1'b1;
        end
        return;
      end
      elapsed = it.now_ms - reported_at;
      if (elapsed < report_period) return;
      reported_at = it.now_ms;
      present = '0;
      alive = '0;
      mism = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (seen[i]) begin
          present[i] = 1'b1;
          age = it.now_ms - seen_at[i];
          if (age < dead_timeout) alive[i] = 1'b1;
          if (version_of[i] != own_version[7:0]) mism[i] = 1'b1;
        end
      end
      dead = present & ~alive;
      payload[BYTE_CODE] = code;
      payload[BYTE_N_PRESENT] = 8'($countones(present));
      payload[BYTE_N_ALIVE] = 8'($countones(alive));
      payload[BYTE_VER_LO] = own_version[7:0];
      payload[BYTE_VER_HI] = own_version[15:8];
      payload[BYTE_FLAGS] = ((mism != 0) ? FLAG_MISMATCH : 8'h00) |
                            ((it.duplicate_mask != 0) ? FLAG_DUPLICATE : 8'h00) |
                            ((dead != 0) ? FLAG_DEAD : 8'h00);
      payload[BYTE_PRESENT_LO] = present[7:0];
      payload[BYTE_PRESENT_HI] = present[15:8];
      payload[BYTE_ALIVE_LO] = alive[7:0];
      payload[BYTE_ALIVE_HI] = alive[15:8];
      payload[BYTE_MISM_LO] = mism[7:0];
      payload[BYTE_MISM_HI] = mism[15:8];
      payload[BYTE_DUP_LO] = it.duplicate_mask[7:0];
      payload[BYTE_DUP_HI] = it.duplicate_mask[15:8];
      payload[BYTE_DEAD_LO] = dead[7:0];
      payload[BYTE_DEAD_HI] = dead[15:8];
      for (int i = 0; i < SLOTS; i++) begin
        if (it.duplicate_mask[i]) status = ST_DUP;
        else if (dead[i]) status = ST_DEAD;
        else if (alive[i]) status = ST_ALIVE;
        else status = ST_NONE;
        payload[SLOT_BASE + 2 * i] = version_of[i];
        payload[SLOT_BASE + 2 * i + 1] = 8'(status);
      end
      for (int k = 0; k < REPORT_LEN; k++) begin
        r.byte_index = CNT_W'(k);
        r.byte_value = payload[k];
        r.last_byte = (k == REPORT_LEN - 1);
        due_bytes.push_back(r);
      end
    endfunction

    task log_mismatch(string msg);
      if (mismatches < MAX_PRINTED) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_byte(result_t got);
      result_t want;
      if (due_bytes.size() == 0) begin
        log_mismatch($sformatf("unexpected byte index %0d value 0x%02h last %0b",
                               got.byte_index, got.byte_value, got.last_byte));
        return;
      end
      want = due_bytes.pop_front();
      if (got.byte_index !== want.byte_index)
        log_mismatch($sformatf("byte_index %0d, want %0d", got.byte_index, want.byte_index));
      if (got.byte_value !== want.byte_value)
        log_mismatch($sformatf("byte %0d value 0x%02h, want 0x%02h",
                               want.byte_index, got.byte_value, want.byte_value));
      if (got.last_byte !== want.last_byte)
        log_mismatch($sformatf("byte %0d last_byte %0b, want %0b",
                               want.byte_index, got.last_byte, want.last_byte));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  item_t item;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic strobe;
  result_t result;

  health_report_model health;
  int stall_cycles;
  logic [31:0] wall_ms;

  node_health_watchdog dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .strobe(strobe),
    .result(result)
  );

  always #(HALF_PERIOD_NS) clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (strobe) health.check_byte(result);
      if ((start && !busy) || strobe || cfg_we) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("[node_health_watchdog] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic item_t frame_item(logic [15:0] id, logic [7:0] ver, logic [31:0] now);
    item_t it;
    it.mode = MODE_FRAME;
    it.node_id = id;
    it.node_version = ver;
    it.now_ms = now;
    it.duplicate_mask = 16'($urandom());
    return it;
  endfunction

  function automatic item_t tick_item(logic [31:0] now, logic [15:0] dup);
    item_t it;
    it.mode = MODE_TICK;
    it.node_id = 16'($urandom());
    it.node_version = 8'($urandom());
    it.now_ms = now;
    it.duplicate_mask = dup;
    return it;
  endfunction

  task automatic send_item(item_t it);
    @(negedge clk);
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    health.take_item(it);
  endtask

  task automatic rest(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (busy || health.due_bytes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    health.write_reg(index, data);
  endtask

  task automatic apply_settings(logic [31:0] dead_ms, logic [31:0] period_ms,
                                logic [15:0] version, logic [15:0] first_id,
                                logic [7:0] code);
    settle();
    write_reg(REG_DEAD_TIMEOUT, dead_ms);
    write_reg(REG_REPORT_PERIOD, period_ms);
    write_reg(REG_EXPECTED_VER, {16'($urandom()), version});
    write_reg(REG_FIRST_NODE, {16'($urandom()), first_id});
    write_reg(REG_REPORT_CODE, {24'($urandom()), code});
    write_reg(CFG_IDX_W'($urandom_range(LAST_REG_INDEX, REG_REPORT_CODE + 1)), $urandom());
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_traffic(int count, int step_max);
    int sent;
    int burst;
    int pick;
    item_t it;
    logic [15:0] id;
    logic [7:0] ver;
    logic [31:0] now;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 10);
      repeat (burst) begin
        wall_ms += $urandom_range(0, step_max);
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          it.mode = 1'($urandom_range(0, 1));
          it.node_id = 16'($urandom());
          it.node_version = 8'($urandom());
          it.now_ms = $urandom();
          it.duplicate_mask = 16'($urandom());
        end else if (pick < 45) begin
          it = tick_item(wall_ms, ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'h0000);
        end else begin
          if (pick < 50) id = health.base_id - 16'd1;
          else if (pick < 54) id = health.base_id + 16'(SLOTS);
          else id = health.base_id + 16'($urandom_range(0, SLOTS - 1));
          ver = ($urandom_range(0, 1) == 0) ? health.own_version[7:0] : 8'($urandom());
          now = ($urandom_range(0, 9) == 0) ? wall_ms - $urandom_range(0, 500) : wall_ms;
          it = frame_item(id, ver, now);
        end
        send_item(it);
        sent++;
      end
      case ($urandom_range(0, 3))
        0: ;
        1: rest($urandom_range(0, 3));
        2: rest($urandom_range(4, 20));
        default: rest($urandom_range(20, 60));
      endcase
    end
  endtask

  initial begin
    health = new();
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    wall_ms = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: too early, then all slots unseen with every duplicate bit set, also above the slots
    send_item(tick_item(32'd999, 16'h0000));
    send_item(tick_item(32'd1000, 16'hFFFF));
    send_item(frame_item(16'd0, 8'h00, 32'd1500));
    send_item(frame_item(16'd11, 8'hFF, 32'hFFFF_FFFF));
    send_item(frame_item(16'd12, 8'h55, 32'd1500));
    send_item(frame_item(16'hFFFF, 8'hAA, 32'd1500));
    send_item(frame_item(16'd5, 8'h01, 32'd1100));
    send_item(tick_item(32'd2000, 16'h0000));
    send_item(tick_item(32'd2999, 16'h0000));
    send_item(tick_item(32'd3000, 16'h0020));

    // zero timeout and period, top of id range
    apply_settings(32'd0, 32'd0, 16'hFFFF, 16'hFFFF - 16'(SLOTS - 1), 8'hFF);
    send_item(frame_item(16'hFFFF - 16'(SLOTS), 8'h11, 32'd0));
    send_item(frame_item(16'hFFFF, 8'hFF, 32'd0));
    send_item(frame_item(16'hFFFF - 16'(SLOTS - 1), 8'h00, 32'd0));
    send_item(tick_item(32'd3000, 16'h0000));
    send_item(tick_item(32'd3000, 16'hF000));

    // largest timeout and period, time wrap
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h5A3C, 16'h0000, 8'h81);
    send_item(frame_item(16'd3, 8'h3C, 32'h8000_0000));
    send_item(tick_item(32'd2999, 16'h0000));
    send_item(tick_item(32'd3000, 16'h0000));

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_settings($urandom_range(0, 200), 32'd0, 16'($urandom()),
                          16'($urandom_range(0, 40)), 8'($urandom()));
        1: apply_settings(32'd0, $urandom_range(0, 60), 16'($urandom()),
                          16'hFFFF - 16'(SLOTS - 1), 8'($urandom()));
        2: apply_settings(32'hFFFF_FFFF, $urandom_range(0, 100), 16'($urandom()),
                          16'($urandom()), 8'($urandom()));
        3: begin
          apply_settings($urandom_range(50, 300), $urandom_range(20, 80), 16'($urandom()),
                         16'($urandom_range(0, 65535)), 8'($urandom()));
          wall_ms = 32'hFFFF_FF00;
        end
        4: apply_settings($urandom(), $urandom_range(0, 100), 16'($urandom()),
                          16'($urandom()), 8'($urandom()));
        default: apply_settings($urandom_range(0, 120), $urandom_range(0, 40), 16'($urandom()),
                                16'($urandom_range(0, 200)), 8'($urandom()));
      endcase
      run_traffic(RANDOM_ITEMS / PHASES, 40);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (health.due_bytes.size() != 0)
      health.log_mismatch($sformatf("%0d report bytes never arrived", health.due_bytes.size()));
    if (health.mismatches == 0) begin
      $display("[node_health_watchdog] OK");
    end else begin
      $display("[node_health_watchdog] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/nhw_pkg.sv
src/nhw_ctrl.sv
src/nhw_dpath.sv
src/node_health_watchdog.sv
dv/node_health_watchdog_test.sv
